[rtl/htnc_pkg.sv]
// Shared types and constants for the tag nesting checker.
`timescale 1ns / 1ps

package htnc_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned MAX_NAME    = 16;

  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PTR_W   = $clog2(STACK_DEPTH);
  localparam int unsigned IDX_W   = $clog2(MAX_NAME + 1);
  localparam int unsigned ADDR_W  = $clog2(STACK_DEPTH * MAX_NAME);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [2:0] {
    ST_VALID    = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_OPEN     = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_LONG     = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] doc_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [5:0] open_count;
  } out_t;

  typedef struct packed {
    logic               in_name;
    logic               closing;
    logic               at_first;
    logic [IDX_W-1:0]   name_idx;
    logic               match;
    logic [DEPTH_W-1:0] depth;
    status_e            err;
  } st_t;

endpackage

[rtl/html_tag_nesting_checker.sv]
// Tag nesting checker: byte-serial tag parser with a name stack in memory.
`timescale 1ns / 1ps

// Takes one document byte per cycle with no bubbles, also across document
// boundaries. The request carrying the last byte of a document yields one
// registered result in the output register; all other bytes yield none.
// The rate is set by the name memory: its single registered read port is
// addressed from the next parser state, so the top-of-stack byte a closing
// name needs is ready when that byte arrives. Input stalls only while a
// result sits in the output register and the far side is stalling.
// Stack memory holds no reset contents and needs no clearing pass; the
// block accepts bytes from the first cycle after reset.
module html_tag_nesting_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  htnc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output htnc_pkg::out_t  out_data_o
);
  import htnc_pkg::*;

  localparam st_t ST_RESET = '{
    in_name:  1'b0,
    closing:  1'b0,
    at_first: 1'b0,
    name_idx: '0,
    match:    1'b1,
    depth:    '0,
    err:      ST_VALID
  };

  st_t              st_q, st_d, s1, s2;
  logic [7:0]       name_mem [STACK_DEPTH*MAX_NAME];
  logic [7:0]       rd_q;
  logic [IDX_W-1:0] len_q [STACK_DEPTH];
  logic             accept;
  logic             wr_en, push_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [PTR_W-1:0] top_ptr, push_ptr, next_top_ptr;
  logic [IDX_W-1:0] top_len;
  logic [7:0]       b;
  logic             out_valid_q;
  out_t             out_q, out_d;
  logic             out_load;

  function automatic logic [ADDR_W-1:0] mem_addr(logic [PTR_W-1:0] ptr,
                                                 logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(ADDR_W'(ptr) * ADDR_W'(MAX_NAME) + ADDR_W'(idx));
    return a;
  endfunction

  // Close the current name: push, or compare length and pop.
  function automatic st_t end_name(st_t s, logic [IDX_W-1:0] tlen);
    st_t r;
    r = s;
    if (!s.closing) begin
      if (s.depth >= DEPTH_W'(STACK_DEPTH)) begin
        if (r.err == ST_VALID) r.err = ST_OVERFLOW;
      end else begin
        r.depth = s.depth + 1'b1;
      end
    end else if (s.depth == '0) begin
      if (r.err == ST_VALID) r.err = ST_MISMATCH;
    end else begin
      if (!s.match || s.name_idx != tlen) begin
        if (r.err == ST_VALID) r.err = ST_MISMATCH;
      end
      r.depth = s.depth - 1'b1;
    end
    r.in_name  = 1'b0;
    r.closing  = 1'b0;
    r.at_first = 1'b0;
    r.name_idx = '0;
    r.match    = 1'b1;
    return r;
  endfunction

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign b          = in_data_i.doc_byte;
  assign top_ptr    = PTR_W'(st_q.depth - 1'b1);
  assign push_ptr   = PTR_W'(st_q.depth);
  assign top_len    = len_q[top_ptr];
  assign wr_addr    = mem_addr(push_ptr, st_q.name_idx);

  always_comb begin
    s1      = st_q;
    wr_en   = 1'b0;
    push_en = 1'b0;
    if (accept) begin
      if (b == CH_LT) begin
        if (st_q.in_name) begin
          s1      = end_name(st_q, top_len);
          push_en = !st_q.closing && (st_q.depth < DEPTH_W'(STACK_DEPTH));
        end
        s1.in_name  = 1'b1;
        s1.at_first = 1'b1;
        s1.closing  = 1'b0;
        s1.name_idx = '0;
        s1.match    = 1'b1;
      end else if (st_q.in_name) begin
        if (b == CH_SP || b == CH_NL || b == CH_GT) begin
          s1      = end_name(st_q, top_len);
          push_en = !st_q.closing && (st_q.depth < DEPTH_W'(STACK_DEPTH));
        end else if (st_q.at_first && b == CH_SLASH) begin
          s1.closing  = 1'b1;
          s1.at_first = 1'b0;
        end else begin
          s1.at_first = 1'b0;
          if (st_q.name_idx >= IDX_W'(MAX_NAME)) begin
            if (s1.err == ST_VALID) s1.err = ST_LONG;
          end else begin
            if (!st_q.closing) begin
              wr_en = st_q.depth < DEPTH_W'(STACK_DEPTH);
            end else if (st_q.depth != '0) begin
              // rd_q holds the top entry's byte at this index
              if (st_q.name_idx >= top_len || rd_q != b) s1.match = 1'b0;
            end
            s1.name_idx = st_q.name_idx + 1'b1;
          end
        end
      end
    end

    // A name still open at the last byte ends there; after '<' this is
    // always an opening name, so the top length is not consulted.
    s2 = s1;
    if (s1.in_name) s2 = end_name(s1, top_len);

    out_load = accept && in_data_i.last;
    out_d.open_count = 6'(s2.depth);
    if (s2.err == ST_VALID && s2.depth != '0) begin
      out_d.status = ST_OPEN;
    end else begin
      out_d.status = s2.err;
    end

    st_d = out_load ? ST_RESET : s1;
  end

  // Fetch the byte that the next request will compare against.
  assign next_top_ptr = PTR_W'(st_d.depth - 1'b1);
  assign rd_addr      = mem_addr(next_top_ptr, st_d.name_idx);

  always_ff @(posedge clk_i) begin
    if (wr_en) name_mem[wr_addr] <= b;
    rd_q <= name_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (push_en) len_q[push_ptr] <= st_q.name_idx;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_RESET;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.depth <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.name_idx <= IDX_W'(MAX_NAME))
    else $error("name index beyond limit");

  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.last |=> out_valid_o)
    else $error("no result after last byte");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.last |=> st_q.depth == '0 && !st_q.in_name &&
                                 st_q.err == ST_VALID)
    else $error("state not cleared after last byte");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.err != ST_VALID && !(accept && in_data_i.last) |=> st_q.err == $past(st_q.err))
    else $error("latched error changed within a document");

endmodule
